// ===== rtl/slr_pkg.sv =====
// Shared constants and helpers for the smallest-range block.
package slr_pkg;

  localparam int DATA_W           = 32;
  localparam int LIST_NUM_W       = 2;
  localparam int BEST_W           = DATA_W + 1;
  localparam int DEF_MAX_LIST_LEN = 1024;
  localparam int DEF_NUM_LISTS    = 3;

  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

  // Signed value to unsigned key that keeps the order.
  function automatic logic [DATA_W-1:0] to_key(input logic [DATA_W-1:0] v);
    return v ^ SIGN_FLIP;
  endfunction

endpackage

// ===== rtl/slr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/slr_minmax.sv =====
// Least and greatest head key across the lists; ties pick the lowest list.
module slr_minmax import slr_pkg::*; #(
  parameter int NUM_LISTS = DEF_NUM_LISTS
) (
  input  logic [NUM_LISTS-1:0][DATA_W-1:0] keys,
  output logic [DATA_W-1:0]                lo_key,
  output logic [DATA_W-1:0]                hi_key,
  output logic [$clog2(NUM_LISTS)-1:0]     lo_idx
);

  localparam int LIST_W = $clog2(NUM_LISTS);

  always_comb begin
    lo_key = keys[0];
    hi_key = keys[0];
    lo_idx = '0;
    for (int i = 1; i < NUM_LISTS; i++) begin
      if (keys[i] < lo_key) begin
        lo_key = keys[i];
        lo_idx = LIST_W'(i);
      end
      if (keys[i] > hi_key) begin
        hi_key = keys[i];
      end
    end
  end

endmodule

// ===== rtl/smallest_range_k_sorted_lists.sv =====
// Smallest range covering one element of each sorted list: load, merge walk, result.
//
// Load items are taken one per cycle while load_stall is low and written straight
// into the list RAM. The item with load_done set starts the merge walk, during
// which the load channel is stalled: the prime state reads the first element of
// every list, then each walk step evaluates the window and issues the next read
// of the list RAM, then takes the read data into the head register in the wait
// state, since every advance waits on the registered RAM read. A load with an
// empty list answers at once with the error flag. The result sits in an output
// register, so the next load may start while it waits; a further load_done item
// waits until it is taken. The list RAM needs no clearing after reset.
module smallest_range_k_sorted_lists import slr_pkg::*; #(
  parameter int MAX_LIST_LEN = DEF_MAX_LIST_LEN,
  parameter int NUM_LISTS    = DEF_NUM_LISTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load_valid,
  output logic                         load_stall,
  input  logic [LIST_NUM_W-1:0]        list_number,
  input  logic signed [DATA_W-1:0]     element_value,
  input  logic                         load_done,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [DATA_W-1:0]            range_width,
  output logic                         empty_list_error
);

  localparam int DEPTH  = NUM_LISTS * MAX_LIST_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIST_W = $clog2(NUM_LISTS);
  localparam int LEN_W  = $clog2(MAX_LIST_LEN + 1);
  localparam int POS_W  = (MAX_LIST_LEN > 1) ? $clog2(MAX_LIST_LEN) : 1;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_PRIME = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_t;

  state_t state;

  logic [LEN_W-1:0]  len      [NUM_LISTS];
  logic [LEN_W-1:0]  len_next [NUM_LISTS];
  logic [POS_W-1:0]  pos      [NUM_LISTS];
  logic [NUM_LISTS-1:0][DATA_W-1:0] head;
  logic [BEST_W-1:0] best;
  logic [BEST_W-1:0] width;
  logic [BEST_W-1:0] best_next;
  logic [LIST_W-1:0] prime_cnt;
  logic              rd_pending;
  logic [LIST_W-1:0] rd_list_q;

  logic              load_fire;
  logic [LIST_W-1:0] sel;
  logic              list_ok;
  logic              any_empty;
  logic              walk_end;
  logic [DATA_W-1:0] lo_key;
  logic [DATA_W-1:0] hi_key;
  logic [LIST_W-1:0] lo_idx;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [LIST_W-1:0] rd_list;
  logic [DATA_W-1:0] rd_data;

  assign load_stall = (state != ST_LOAD) || (result_valid && load_done);
  assign load_fire  = load_valid && !load_stall;
  assign sel        = LIST_W'(list_number);
  assign list_ok    = (int'(list_number) < NUM_LISTS) &&
                      (int'(len[sel]) < MAX_LIST_LEN);

  always_comb begin
    any_empty = 1'b0;
    for (int i = 0; i < NUM_LISTS; i++) begin
      len_next[i] = len[i];
      if (wr_en && sel == LIST_W'(i)) begin
        len_next[i] = len[i] + LEN_W'(1);
      end
      if (len_next[i] == '0) begin
        any_empty = 1'b1;
      end
    end
  end

  slr_minmax #(
    .NUM_LISTS(NUM_LISTS)
  ) u_minmax (
    .keys  (head),
    .lo_key(lo_key),
    .hi_key(hi_key),
    .lo_idx(lo_idx)
  );

  assign width     = {1'b0, hi_key - lo_key};
  assign best_next = (width < best) ? width : best;
  assign walk_end  = ((LEN_W + 1)'(pos[lo_idx]) + (LEN_W + 1)'(1)) >=
                     (LEN_W + 1)'(len[lo_idx]);

  always_comb begin
    wr_en   = load_fire && list_ok;
    wr_addr = ADDR_W'(sel) * ADDR_W'(MAX_LIST_LEN) + ADDR_W'(len[sel]);
    rd_en   = 1'b0;
    rd_list = '0;
    rd_addr = '0;
    case (state)
      ST_PRIME: begin
        rd_en   = 1'b1;
        rd_list = prime_cnt;
        rd_addr = ADDR_W'(prime_cnt) * ADDR_W'(MAX_LIST_LEN);
      end
      ST_EVAL: begin
        rd_en   = !walk_end;
        rd_list = lo_idx;
        rd_addr = ADDR_W'(lo_idx) * ADDR_W'(MAX_LIST_LEN) +
                  ADDR_W'(pos[lo_idx]) + ADDR_W'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  slr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(element_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      len          <= '{default: '0};
      pos          <= '{default: '0};
      best         <= '1;
      prime_cnt    <= '0;
      rd_pending   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      rd_list_q  <= rd_list;
      if (rd_pending) begin
        head[rd_list_q] <= to_key(rd_data);
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (load_fire) begin
            if (load_done && any_empty) begin
              result_valid     <= 1'b1;
              range_width      <= '0;
              empty_list_error <= 1'b1;
              len              <= '{default: '0};
            end else begin
              len <= len_next;
              if (load_done) begin
                prime_cnt <= '0;
                state     <= ST_PRIME;
              end
            end
          end
        end
        ST_PRIME: begin
          prime_cnt <= prime_cnt + LIST_W'(1);
          if (prime_cnt == LIST_W'(NUM_LISTS - 1)) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (walk_end) begin
            result_valid     <= 1'b1;
            range_width      <= best_next[DATA_W-1:0];
            empty_list_error <= 1'b0;
            len              <= '{default: '0};
            pos              <= '{default: '0};
            best             <= '1;
            state            <= ST_LOAD;
          end else begin
            best        <= best_next;
            pos[lo_idx] <= pos[lo_idx] + POS_W'(1);
            state       <= ST_WAIT;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_rd_source: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> $past(state == ST_PRIME || state == ST_EVAL))
    else $error("head read without an issuing state");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_LOAD || state == ST_EVAL))
    else $error("result raised outside load or walk end");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && empty_list_error) |-> (range_width == '0))
    else $error("flagged result with nonzero width");

  a_eval_after_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> $past(state == ST_WAIT))
    else $error("window evaluated without settled heads");

  a_heads_settled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> !rd_pending)
    else $error("head read still pending at evaluation");

endmodule
